[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Wrap concurrent assertions so a build can compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[hw/rtl/hrm_pkg.sv]
// ----------------------------------------------------------------------------
// hrm_pkg
// Types, widths and constants of the hue rotation matrix generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrm_pkg;

   // Angle and coefficient formats
   localparam int ANGLE_BITS     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int REM_W          = ANGLE_BITS - 2;
   localparam int COEF_W         = 16;

   // Internal Q30 datapath widths
   localparam int T_W    = 31;                 // quarter-wave argument
   localparam int U_W    = 32;                 // argument squared
   localparam int P_W    = 31;                 // Horner partial
   localparam int M_W    = 32;                 // u * p, scaled back
   localparam int S_W    = 32;                 // raw sine
   localparam int SC_W   = 33;                 // folded sine / cosine, signed
   localparam int TM_W   = 34;                 // |sin| * sqrt3 magnitude
   localparam int NUM_W  = 36;                 // numerator, signed
   localparam int PROD_W = NUM_W + 9;          // numerator * opacity

   // Q30 constants
   localparam logic [P_W-1:0] ONE_Q30     = P_W'(32'h4000_0000);
   localparam logic [30:0]    HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0]    SQRT3_Q30   = 31'd1859775393;

   // Horner divisors as reciprocal multiply and shift, exact for 32-bit values
   localparam int NUM_ITERS = 5;
   localparam int unsigned SIN_SHIFT [NUM_ITERS] = '{39, 39, 38, 37, 35};
   localparam int unsigned COS_SHIFT [NUM_ITERS] = '{40, 39, 38, 37, 36};
   localparam logic [32:0] SIN_RECIP [NUM_ITERS] = '{
      33'((65'd1 << 39) / 110 + 1),
      33'((65'd1 << 39) / 72 + 1),
      33'((65'd1 << 38) / 42 + 1),
      33'((65'd1 << 37) / 20 + 1),
      33'((65'd1 << 35) / 6 + 1)
   };
   localparam logic [32:0] COS_RECIP [NUM_ITERS] = '{
      33'((65'd1 << 40) / 132 + 1),
      33'((65'd1 << 39) / 90 + 1),
      33'((65'd1 << 38) / 56 + 1),
      33'((65'd1 << 37) / 30 + 1),
      33'((65'd1 << 36) / 12 + 1)
   };

   // Final scale: divide by 3 * 255 * 2^DEN_SHIFT with rounding
   localparam int DEN_SHIFT = 30 - COEF_FRAC_BITS;
   localparam int COEF_DIV  = 765;
   localparam logic [PROD_W:0] DIV_BIAS = (PROD_W + 1)'(COEF_DIV) << (DEN_SHIFT - 1);
   localparam int X_W       = PROD_W + 1 - DEN_SHIFT;
   localparam int DIV_SHIFT = X_W + 10;
   localparam logic [X_W:0] DIV_RECIP = (X_W + 1)'((64'd1 << DIV_SHIFT) / COEF_DIV + 1);
   localparam int QUO_W     = 21;

   // Saturation bounds
   localparam int COEF_POS_MAG = 32767;
   localparam int COEF_NEG_MAG = 32768;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

   // Numerator kinds
   localparam int NUM_DIAG  = 0;
   localparam int NUM_PLUS  = 1;
   localparam int NUM_MINUS = 2;
   localparam int NUM_KINDS = 3;

   // Pipeline stage positions
   localparam int ST_T       = 0;
   localparam int ST_U       = 1;
   localparam int ST_SC      = ST_U + 2 * NUM_ITERS + 1;
   localparam int ST_FOLD    = ST_SC + 1;
   localparam int ST_TMAG    = ST_FOLD + 1;
   localparam int ST_NUM     = ST_TMAG + 1;
   localparam int ST_PROD    = ST_NUM + 1;
   localparam int ST_BIAS    = ST_PROD + 1;
   localparam int ST_QUO     = ST_BIAS + 1;
   localparam int ST_OUT     = ST_QUO + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef enum logic [1:0] {
      QUAD_I   = 2'd0,
      QUAD_II  = 2'd1,
      QUAD_III = 2'd2,
      QUAD_IV  = 2'd3
   } hrm_quad_type;

   typedef struct packed {
      logic [15:0] hue_angle;
      logic [7:0]  opacity;
   } hrm_req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_00;
      logic signed [COEF_W-1:0] coef_01;
      logic signed [COEF_W-1:0] coef_02;
      logic signed [COEF_W-1:0] coef_10;
      logic signed [COEF_W-1:0] coef_11;
      logic signed [COEF_W-1:0] coef_12;
      logic signed [COEF_W-1:0] coef_20;
      logic signed [COEF_W-1:0] coef_21;
      logic signed [COEF_W-1:0] coef_22;
   } hrm_rsp_type;

   typedef struct packed {
      hrm_quad_type quad;
      logic [7:0]   opa;
   } hrm_side_type;

   // Apply sign and clamp a rounded magnitude to a 16-bit coefficient
   function automatic logic signed [COEF_W-1:0] sat_coef(
      input logic [QUO_W-1:0] mag,
      input logic             neg
   );
      logic signed [COEF_W-1:0] res;
      if (neg) begin
         if (mag >= QUO_W'(COEF_NEG_MAG)) res = COEF_MIN;
         else res = COEF_W'(0) - COEF_W'(mag);
      end else begin
         if (mag > QUO_W'(COEF_POS_MAG)) res = COEF_MAX;
         else res = COEF_W'(mag);
      end
      return res;
   endfunction

endpackage

[hw/rtl/hue_rotation_matrix_gen.sv]
// ----------------------------------------------------------------------------
// hue_rotation_matrix_gen
// Throughput: one transfer per cycle through 20 register stages, unless rsp_stall holds a full pipeline.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hue_rotation_matrix_gen (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hrm_pkg::hrm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hrm_pkg::hrm_rsp_type rsp_data
);
   import hrm_pkg::*;

   localparam int NS = NUM_STAGES;

   // ------------------------------------------------------------------
   // Stage control: a stage loads when the output is not stalled or any stage from it onward is empty
   // ------------------------------------------------------------------
   logic [NS-1:0] valid_ff, valid_in, en, up_valid;

   genvar g;
   for (g = 0; g < NS; g++) begin : g_en
      assign en[g] = !rsp_stall || !(&valid_ff[NS-1:g]);
   end

   assign up_valid = {valid_ff[NS-2:0], req_valid};
   assign valid_in = (en & up_valid) | (~en & valid_ff);
   assign req_stall = !en[ST_T];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   // ------------------------------------------------------------------
   // Shift lines for argument, square and side data
   // ------------------------------------------------------------------
   logic [T_W-1:0]  t_ff    [ST_T:ST_SC-1];
   logic [U_W-1:0]  u_ff    [ST_U:ST_SC-1];
   hrm_side_type    side_ff [ST_T:ST_SC];
   logic [7:0]      opa_ff  [ST_FOLD:ST_NUM];

   // Scale the quarter-wave remainder to radians
   logic [REM_W+30:0] t_prod;
   assign t_prod = req_data.hue_angle[REM_W-1:0] * HALF_PI_Q30;

   always_ff @(posedge clock) begin
      if (en[ST_T]) begin
         t_ff[ST_T]         <= t_prod[REM_W+30:REM_W];
         side_ff[ST_T].quad <= hrm_quad_type'(req_data.hue_angle[ANGLE_BITS-1 -: 2]);
         side_ff[ST_T].opa  <= req_data.opacity;
      end
   end

   // Square the argument
   logic [2*T_W-1:0] u_prod;
   assign u_prod = t_ff[ST_T] * t_ff[ST_T];

   always_ff @(posedge clock) begin
      if (en[ST_U]) u_ff[ST_U] <= u_prod[61:30];
   end

   for (g = ST_T + 1; g < ST_SC; g++) begin : g_t_line
      always_ff @(posedge clock) begin
         if (en[g]) t_ff[g] <= t_ff[g-1];
      end
   end

   for (g = ST_U + 1; g < ST_SC; g++) begin : g_u_line
      always_ff @(posedge clock) begin
         if (en[g]) u_ff[g] <= u_ff[g-1];
      end
   end

   for (g = ST_T + 1; g <= ST_SC; g++) begin : g_side_line
      always_ff @(posedge clock) begin
         if (en[g]) side_ff[g] <= side_ff[g-1];
      end
   end

   // ------------------------------------------------------------------
   // Horner steps: p = one - floor(floor(u*p/2^30) / k), two stages each
   // ------------------------------------------------------------------
   logic [M_W-1:0] ms_ff [NUM_ITERS];
   logic [M_W-1:0] mc_ff [NUM_ITERS];
   logic [P_W-1:0] ps_ff [NUM_ITERS];
   logic [P_W-1:0] pc_ff [NUM_ITERS];

   for (g = 0; g < NUM_ITERS; g++) begin : g_iter
      localparam int SM = ST_U + 1 + 2 * g;
      localparam int SP = SM + 1;
      logic [P_W-1:0]      ps_prev, pc_prev, ps_in, pc_in;
      logic [U_W+P_W-1:0]  ms_prod, mc_prod;
      logic [M_W+32:0]     qs_prod, qc_prod;

      if (g == 0) begin : g_first
         assign ps_prev = ONE_Q30;
         assign pc_prev = ONE_Q30;
      end else begin : g_next
         assign ps_prev = ps_ff[g-1];
         assign pc_prev = pc_ff[g-1];
      end

      // Multiply by the running partial
      assign ms_prod = u_ff[SM-1] * ps_prev;
      assign mc_prod = u_ff[SM-1] * pc_prev;

      always_ff @(posedge clock) begin
         if (en[SM]) begin
            ms_ff[g] <= ms_prod[61:30];
            mc_ff[g] <= mc_prod[61:30];
         end
      end

      // Divide by the step constant through its reciprocal
      assign qs_prod = ms_ff[g] * SIN_RECIP[g];
      assign qc_prod = mc_ff[g] * COS_RECIP[g];
      assign ps_in   = ONE_Q30 - P_W'(qs_prod >> SIN_SHIFT[g]);
      assign pc_in   = ONE_Q30 - P_W'(qc_prod >> COS_SHIFT[g]);

      always_ff @(posedge clock) begin
         if (en[SP]) begin
            ps_ff[g] <= ps_in;
            pc_ff[g] <= pc_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Raw sine and last cosine product
   // ------------------------------------------------------------------
   logic [S_W-1:0]       s_ff;
   logic [M_W-1:0]       m_fin_ff;
   logic [T_W+P_W-1:0]   s_prod;
   logic [U_W+P_W-1:0]   m_fin_prod;

   assign s_prod     = t_ff[ST_SC-1] * ps_ff[NUM_ITERS-1];
   assign m_fin_prod = u_ff[ST_SC-1] * pc_ff[NUM_ITERS-1];

   always_ff @(posedge clock) begin
      if (en[ST_SC]) begin
         s_ff     <= s_prod[61:30];
         m_fin_ff <= m_fin_prod[61:30];
      end
   end

   // ------------------------------------------------------------------
   // Finish cosine and fold by quadrant
   // ------------------------------------------------------------------
   logic signed [SC_W-1:0] s_val, c_val, sn_in, cs_in;
   logic signed [SC_W-1:0] sn_ff;
   logic signed [SC_W-1:0] cs_ff [ST_FOLD:ST_TMAG];

   always_comb begin
      s_val = signed'(SC_W'(s_ff));
      c_val = signed'(SC_W'(ONE_Q30)) - signed'(SC_W'(m_fin_ff[M_W-1:1]));
      case (side_ff[ST_SC].quad)
         QUAD_I: begin
            sn_in = s_val;
            cs_in = c_val;
         end
         QUAD_II: begin
            sn_in = c_val;
            cs_in = -s_val;
         end
         QUAD_III: begin
            sn_in = -s_val;
            cs_in = -c_val;
         end
         default: begin
            sn_in = -c_val;
            cs_in = s_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[ST_FOLD]) begin
         sn_ff          <= sn_in;
         cs_ff[ST_FOLD] <= cs_in;
         opa_ff[ST_FOLD] <= side_ff[ST_SC].opa;
      end
   end

   // ------------------------------------------------------------------
   // Sine times sqrt3 in sign-magnitude, truncated toward zero
   // ------------------------------------------------------------------
   logic [SC_W-1:0]    sn_mag;
   logic [SC_W+30:0]   tm_prod;
   logic [TM_W-1:0]    tmag_ff;
   logic               tneg_ff;

   assign sn_mag  = sn_ff[SC_W-1] ? SC_W'(-sn_ff) : SC_W'(sn_ff);
   assign tm_prod = sn_mag * SQRT3_Q30;

   always_ff @(posedge clock) begin
      if (en[ST_TMAG]) begin
         tmag_ff         <= tm_prod[SC_W+30:30];
         tneg_ff         <= sn_ff[SC_W-1];
         cs_ff[ST_TMAG]  <= cs_ff[ST_FOLD];
         opa_ff[ST_TMAG] <= opa_ff[ST_FOLD];
      end
   end

   // ------------------------------------------------------------------
   // Numerators: one + 2cos and (one - cos) +/- T
   // ------------------------------------------------------------------
   logic signed [NUM_W-1:0] t_val, cs_x, one_x, base;
   logic signed [NUM_W-1:0] num_in [NUM_KINDS];
   logic signed [NUM_W-1:0] num_ff [NUM_KINDS];

   always_comb begin
      t_val = NUM_W'(tmag_ff);
      if (tneg_ff) t_val = -t_val;
      cs_x  = NUM_W'(cs_ff[ST_TMAG]);
      one_x = NUM_W'(ONE_Q30);
      base  = one_x - cs_x;
      num_in[NUM_DIAG]  = one_x + (cs_x <<< 1);
      num_in[NUM_PLUS]  = base + t_val;
      num_in[NUM_MINUS] = base - t_val;
   end

   always_ff @(posedge clock) begin
      if (en[ST_NUM]) begin
         num_ff         <= num_in;
         opa_ff[ST_NUM] <= opa_ff[ST_TMAG];
      end
   end

   // ------------------------------------------------------------------
   // Scale by opacity
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod_in [NUM_KINDS];
   logic signed [PROD_W-1:0] prod_ff [NUM_KINDS];

   always_comb begin
      for (int k = 0; k < NUM_KINDS; k++) begin
         prod_in[k] = num_ff[k] * $signed({1'b0, opa_ff[ST_NUM]});
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) prod_ff <= prod_in;
   end

   // ------------------------------------------------------------------
   // Take magnitude, add half the divisor, drop the power-of-two part
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] pmag;
   logic [PROD_W:0]   psum [NUM_KINDS];
   logic [X_W-1:0]    x_ff [NUM_KINDS];
   logic [NUM_KINDS-1:0] xneg_ff;

   always_comb begin
      pmag = '0;
      for (int k = 0; k < NUM_KINDS; k++) begin
         pmag    = prod_ff[k][PROD_W-1] ? PROD_W'(-prod_ff[k]) : PROD_W'(prod_ff[k]);
         psum[k] = (PROD_W + 1)'(pmag) + DIV_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_BIAS]) begin
         for (int k = 0; k < NUM_KINDS; k++) begin
            x_ff[k]    <= psum[k][PROD_W:DEN_SHIFT];
            xneg_ff[k] <= prod_ff[k][PROD_W-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Divide by 765 through its reciprocal
   // ------------------------------------------------------------------
   logic [2*X_W:0]       qprod [NUM_KINDS];
   logic [QUO_W-1:0]     q_ff  [NUM_KINDS];
   logic [NUM_KINDS-1:0] qneg_ff;

   always_comb begin
      for (int k = 0; k < NUM_KINDS; k++) begin
         qprod[k] = x_ff[k] * DIV_RECIP;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_QUO]) begin
         for (int k = 0; k < NUM_KINDS; k++) begin
            q_ff[k] <= QUO_W'(qprod[k] >> DIV_SHIFT);
         end
         qneg_ff <= xneg_ff;
      end
   end

   // ------------------------------------------------------------------
   // Saturate and place the coefficients in the output register
   // ------------------------------------------------------------------
   logic signed [COEF_W-1:0] diag_c, plus_c, minus_c;
   hrm_rsp_type              rsp_in, rsp_ff;

   always_comb begin
      diag_c  = sat_coef(q_ff[NUM_DIAG], qneg_ff[NUM_DIAG]);
      plus_c  = sat_coef(q_ff[NUM_PLUS], qneg_ff[NUM_PLUS]);
      minus_c = sat_coef(q_ff[NUM_MINUS], qneg_ff[NUM_MINUS]);
      rsp_in.coef_00 = diag_c;
      rsp_in.coef_01 = plus_c;
      rsp_in.coef_02 = minus_c;
      rsp_in.coef_10 = minus_c;
      rsp_in.coef_11 = diag_c;
      rsp_in.coef_12 = plus_c;
      rsp_in.coef_20 = plus_c;
      rsp_in.coef_21 = minus_c;
      rsp_in.coef_22 = diag_c;
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_NEVER(a_stall_with_gap, clock, reset, req_stall && !(&valid_ff), "request stalled with an empty stage")
   `ASSERT_CLK(a_entry_valid, clock, reset, (req_valid && !req_stall) |=> valid_ff[ST_T], "accepted transfer missing from first stage")
   `ASSERT_CLK(a_occupancy, clock, reset, !$past(reset) |-> (($countones(valid_ff) + $past(rsp_valid && !rsp_stall)) == ($past($countones(valid_ff)) + $past(req_valid && !req_stall))), "pipeline occupancy does not match transfers")

endmodule

[tb/tb_hue_rotation_matrix_gen.sv]
// ----------------------------------------------------------------------------
// tb_hue_rotation_matrix_gen
// Drives hue angle / opacity requests into the matrix generator under random
// valid gaps and output stalls, predicts every coefficient matrix in 64-bit
// fixed point and compares each returned transfer field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hue_rotation_matrix_gen;
   import hrm_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int LATENCY         = 20;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_REPORTS     = 10;
   localparam int NUM_COEFS       = 9;

   // Predicts coefficient matrices and checks them against returned transfers
   class coef_scoreboard;
      localparam longint UNITY_FX            = 64'sd1 << 30;
      localparam longint unsigned HALF_PI_FX = 64'd1686629713;
      localparam longint unsigned SQRT3_FX   = 64'd1859775393;
      localparam longint unsigned COEF_DEN   = 64'd765 << (30 - COEF_FRAC_BITS);

      longint unsigned sine_divs [5]   = '{110, 72, 42, 20, 6};
      longint unsigned cosine_divs [5] = '{132, 90, 56, 30, 12};
      string coef_names [NUM_COEFS] = '{"coef_00", "coef_01", "coef_02",
                                        "coef_10", "coef_11", "coef_12",
                                        "coef_20", "coef_21", "coef_22"};
      hrm_rsp_type pending_matrices [$];
      int unsigned noted    = 0;
      int unsigned checked  = 0;
      int unsigned failures = 0;

      // Round to nearest with ties away from zero, then clamp to 16 bits
      function logic signed [COEF_W-1:0] round_coef(longint num);
         longint unsigned mag, q;
         logic signed [COEF_W-1:0] res;
         mag = (num < 0) ? -num : num;
         q = (mag + COEF_DEN / 2) / COEF_DEN;
         if (num < 0) begin
            if (q >= 64'd32768) res = 16'sh8000;
            else res = COEF_W'(64'd0 - q);
         end else begin
            if (q > 64'd32767) res = 16'sh7FFF;
            else res = COEF_W'(q);
         end
         return res;
      endfunction

      function hrm_rsp_type rotate_matrix(hrm_req_type item);
         longint unsigned r, t, u, p, mag;
         longint s, c, sn, cs, tm, opa, diag, base, plus_n, minus_n;
         hrm_quad_type quad;
         hrm_rsp_type m;
         quad = hrm_quad_type'(item.hue_angle[ANGLE_BITS-1 -: 2]);
         r = item.hue_angle[REM_W-1:0];
         opa = item.opacity;
         // quarter-wave sine and cosine by Horner series
         t = (r * HALF_PI_FX) >> REM_W;
         u = (t * t) >> 30;
         p = UNITY_FX;
         for (int i = 0; i < 5; i++) p = UNITY_FX - ((u * p) >> 30) / sine_divs[i];
         s = (t * p) >> 30;
         p = UNITY_FX;
         for (int i = 0; i < 5; i++) p = UNITY_FX - ((u * p) >> 30) / cosine_divs[i];
         c = UNITY_FX - longint'(((u * p) >> 30) / 2);
         // fold by quadrant
         case (quad)
            QUAD_I: begin
               sn = s;
               cs = c;
            end
            QUAD_II: begin
               sn = c;
               cs = -s;
            end
            QUAD_III: begin
               sn = -s;
               cs = -c;
            end
            default: begin
               sn = -c;
               cs = s;
            end
         endcase
         // sin * sqrt3 term, truncated toward zero
         mag = (sn < 0) ? -sn : sn;
         tm = longint'((mag * SQRT3_FX) >> 30);
         if (sn < 0) tm = -tm;
         diag    = (UNITY_FX + 2 * cs) * opa;
         base    = UNITY_FX - cs;
         plus_n  = (base + tm) * opa;
         minus_n = (base - tm) * opa;
         m.coef_00 = round_coef(diag);
         m.coef_11 = round_coef(diag);
         m.coef_22 = round_coef(diag);
         m.coef_01 = round_coef(plus_n);
         m.coef_12 = round_coef(plus_n);
         m.coef_20 = round_coef(plus_n);
         m.coef_02 = round_coef(minus_n);
         m.coef_10 = round_coef(minus_n);
         m.coef_21 = round_coef(minus_n);
         return m;
      endfunction

      function logic signed [COEF_W-1:0] coef_at(hrm_rsp_type v, int idx);
         return v[COEF_W*(NUM_COEFS-1-idx) +: COEF_W];
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
      endfunction

      function void note_request(hrm_req_type item);
         pending_matrices.push_back(rotate_matrix(item));
         noted++;
      endfunction

      function void check_result(hrm_rsp_type got);
         hrm_rsp_type want;
         checked++;
         if (pending_matrices.size() == 0) begin
            flag_failure($sformatf("result %0d arrived with nothing outstanding: %h",
                                   checked, got));
            return;
         end
         want = pending_matrices.pop_front();
         for (int i = 0; i < NUM_COEFS; i++) begin
            if (coef_at(got, i) !== coef_at(want, i))
               flag_failure($sformatf("result %0d %s expected %0d got %0d", checked,
                                      coef_names[i], coef_at(want, i), coef_at(got, i)));
         end
      endfunction

      function int unsigned pending();
         return pending_matrices.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   hrm_req_type req_data   = '0;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   hrm_rsp_type rsp_data;

   coef_scoreboard sb = new;
   bit          hold_off_req = 1'b0;
   int unsigned hold_offs = 0;
   int unsigned backpressure_cycles = 0;
   int unsigned idle_cycles = 0;

   // quadrant edges, zero / full / odd opacity, familiar angles
   hrm_req_type corner_reqs [23] = '{
      '{16'h0000, 8'd255}, '{16'h0000, 8'd0},   '{16'h0001, 8'd255},
      '{16'h3FFF, 8'd255}, '{16'h4000, 8'd255}, '{16'h4001, 8'd1},
      '{16'h7FFF, 8'd128}, '{16'h8000, 8'd255}, '{16'h8001, 8'd255},
      '{16'hBFFF, 8'd255}, '{16'hC000, 8'd255}, '{16'hC001, 8'd127},
      '{16'hFFFF, 8'd255}, '{16'hFFFF, 8'd0},   '{16'h2AAB, 8'd255},
      '{16'h5555, 8'd255}, '{16'hAAAB, 8'd200}, '{16'hD555, 8'd255},
      '{16'h1000, 8'd1},   '{16'h6000, 8'd254}, '{16'h9000, 8'd0},
      '{16'hE000, 8'd255}, '{16'h8000, 8'd1}
   };

   hue_rotation_matrix_gen u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Record transfers on both channels and watch for a hung pipeline
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && req_stall) backpressure_cycles++;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stall the result channel: free runs, short stalls, rare long ones
   initial begin
      int unsigned mode;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         mode = $urandom_range(0, 99);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            hold_offs++;
         end else if (mode < 45) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else if (mode < 93) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 50)) @(posedge clock);
         end
      end
   end

   function automatic hrm_req_type random_request();
      hrm_req_type item;
      int unsigned pick;
      item.hue_angle = 16'($urandom);
      item.opacity   = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         item.opacity = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      end else if (pick == 1) begin
         // land close to a quadrant boundary
         if ($urandom_range(0, 1) != 0) item.hue_angle[REM_W-1:0] = REM_W'($urandom_range(0, 7));
         else item.hue_angle[REM_W-1:0] = REM_W'(16383 - $urandom_range(0, 7));
      end
      return item;
   endfunction

   function automatic int sender_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      else if (pick < 95) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // Offer one request and hold it until the transfer
   task automatic send_request(input hrm_req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_batch(input int unsigned count, input bit with_gaps);
      int gap;
      for (int unsigned n = 0; n < count; n++) begin
         send_request(random_request());
         gap = with_gaps ? sender_gap() : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and wait for every outstanding matrix
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, back to back
      foreach (corner_reqs[i]) send_request(corner_reqs[i]);

      // random with gaps on both sides
      send_batch(450, 1'b1);

      // long output hold-off while requests keep coming
      hold_off_req = 1'b1;
      send_batch(150, 1'b0);
      wait_drained();

      // full-rate stretch, then gaps again
      send_batch(300, 1'b0);
      send_batch(330, 1'b1);

      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Summary: %0d requests (%0d directed corners), %0d matrices compared",
               sb.noted, $size(corner_reqs), sb.checked);
      $display("Summary: %0d input back-pressure cycles, %0d long output hold-offs, %0d mismatches",
               backpressure_cycles, hold_offs, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
